// ===== rtl/assert_macros.svh =====
// assertion macros used by the percentile_contrast_stretch rtl
// no dependencies; empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define PCS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PCS_ASSERT(label, clk, rst_n, prop)
`define PCS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/pcs_pkg.sv =====
// package for the percentile contrast stretch: word types and constants
// no dependencies
`default_nettype none
package pcs_pkg;
  localparam int unsigned MaxPixelsDefault = 1048576;
  localparam int unsigned NumLevels = 256;
  localparam logic [0:0] CfgLowDefault  = 1'b0;
  localparam logic [0:0] CfgHighDefault = 1'b1;
  localparam logic OpHist = 1'b0;
  localparam logic OpMap  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_value;
    logic       frame_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] stretched_pixel;
    logic       result_last;
    logic [7:0] low_point;
    logic [7:0] high_point;
  } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/percentile_contrast_stretch.sv =====
// histogram pass: each word is read, then written back; the last word adds a
// bin scan of the histogram memory (one settling read, then one bin per
// cycle). mapping pass: pixels between levels go through the bit-serial divider;
// any output stall holds the finished word back.
// the mapping word that ends a frame adds a clearing sweep.
// reset: a clearing sweep of the histogram memory runs first;
// total, levels and configuration take their reset values at once.
`include "assert_macros.svh"
`default_nettype none
module percentile_contrast_stretch #(
  parameter int unsigned MAX_PIXELS = pcs_pkg::MaxPixelsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pcs_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pcs_pkg::out_word_t     out_word_o,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i
);
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_PIXELS);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StHist  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  // histogram memory
  logic [CW-1:0] hist_mem [pcs_pkg::NumLevels];
  logic [CW-1:0] rd_data_q;
  logic [7:0]    rd_addr;
  logic          wr_en;
  logic [7:0]    wr_addr;
  logic [CW-1:0] wr_data;

  logic [2:0]    state_q, state_d;
  logic [7:0]    idx_q, idx_d;
  logic [CW-1:0] total_q, total_d;
  logic [7:0]    low_q, low_d, high_q, high_d;
  logic [7:0]    low_def_q, high_def_q;
  logic [CW+3:0] cum_q, cum_d;
  logic          found_q, found_d;
  logic [7:0]    lo_run_q, lo_run_d;
  logic          scan_rd_q, scan_rd_d;
  pcs_pkg::in_word_t cur_q, cur_d;
  pcs_pkg::out_word_t out_q, out_d;
  logic          ovalid_q, ovalid_d;
  logic          clr_after_q, clr_after_d;
  logic          div_start;
  logic          div_done;
  logic [7:0]    div_quot;
  logic [16:0]   div_num;
  logic [9:0]    div_den;
  logic          accept;
  logic [CW+3:0] cum_next;
  logic [CW+3:0] tot_ext;

  assign in_stall_o = (state_q != StIdle) || (ovalid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign tot_ext    = {4'd0, total_q};
  assign cum_next   = cum_q + {4'd0, rd_data_q};

  // memory port: registered read, single write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_def_q  <= 8'd0;
      high_def_q <= 8'd255;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pcs_pkg::CfgLowDefault) begin
        low_def_q <= cfg_data_i;
      end else if (cfg_index_i == pcs_pkg::CfgHighDefault) begin
        high_def_q <= cfg_data_i;
      end
    end
  end

  // divider operands: round((v-low)*255/span) = (2*255*(v-low)+span)/(2*span)
  assign div_num = 17'({1'b0, 8'(cur_q.pixel_value - low_q)} * 17'd510)
                   + 17'({1'b0, 8'(high_q - low_q)}) + 17'd1;
  assign div_den = {9'({1'b0, 8'(high_q - low_q)} + 9'd1), 1'b0};

  pcs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // main sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    total_d     = total_q;
    low_d       = low_q;
    high_d      = high_q;
    cum_d       = cum_q;
    found_d     = found_q;
    lo_run_d    = lo_run_q;
    scan_rd_d   = 1'b0;
    cur_d       = cur_q;
    out_d       = out_q;
    ovalid_d    = ovalid_q && out_stall_i;
    clr_after_d = clr_after_q;
    rd_addr     = in_word_i.pixel_value;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;
    div_start   = 1'b0;
    case (state_q)
      StClear: begin
        wr_en = 1'b1;
        idx_d = idx_q + 8'd1;
        if (idx_q == 8'd255) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          cur_d = in_word_i;
          if (in_word_i.operation == pcs_pkg::OpHist) begin
            state_d = StHist;
          end else begin
            out_d.result_last = in_word_i.frame_last;
            out_d.low_point   = low_q;
            out_d.high_point  = high_q;
            clr_after_d       = in_word_i.frame_last;
            if (in_word_i.pixel_value < low_q) begin
              out_d.stretched_pixel = 8'd0;
              state_d = StOut;
            end else if (in_word_i.pixel_value > high_q) begin
              out_d.stretched_pixel = 8'd255;
              state_d = StOut;
            end else begin
              state_d = StDiv;
            end
          end
        end
      end
      StHist: begin
        wr_en   = 1'b1;
        wr_addr = cur_q.pixel_value;
        wr_data = (rd_data_q < MaxCount) ? rd_data_q + CW'(1) : rd_data_q;
        if (total_q < MaxCount) begin
          total_d = total_q + CW'(1);
        end
        if (cur_q.frame_last) begin
          // scan starts once this write back has landed
          state_d   = StScan;
          idx_d     = 8'd0;
          cum_d     = '0;
          found_d   = 1'b0;
          lo_run_d  = low_def_q;
        end else begin
          state_d = StIdle;
        end
      end
      StScan: begin
        // one bin per cycle; read of next bin issued alongside
        rd_addr   = scan_rd_q ? idx_q + 8'd1 : idx_q;
        scan_rd_d = 1'b1;
        if (scan_rd_q) begin
          cum_d = cum_next;
          if (!found_q) begin
            if ((cum_next * 10) < {4'd0, total_q}) begin
              lo_run_d = idx_q;
            end
            if ((cum_next * 10) > ((tot_ext << 3) + tot_ext)) begin
              found_d = 1'b1;
              high_d  = idx_q;
            end
          end
          idx_d = idx_q + 8'd1;
          if (idx_q == 8'd255) begin
            low_d = (!found_q && ((cum_next * 10) < tot_ext)) ? idx_q : lo_run_q;
            if (!found_q && !((cum_next * 10) > ((tot_ext << 3) + tot_ext))) begin
              high_d = high_def_q;
            end else if (found_q) begin
              high_d = high_q;
            end
            state_d = StIdle;
          end
        end
      end
      StDiv: begin
        div_start = (idx_q == 8'd0);
        idx_d     = 8'd1;
        if (div_done) begin
          out_d.stretched_pixel = div_quot;
          idx_d   = 8'd0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!(ovalid_q && out_stall_i)) begin
          ovalid_d = 1'b1;
          if (clr_after_q) begin
            clr_after_d = 1'b0;
            total_d     = '0;
            idx_d       = 8'd0;
            state_d     = StClear;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      idx_q       <= 8'd0;
      total_q     <= '0;
      low_q       <= 8'd0;
      high_q      <= 8'd255;
      ovalid_q    <= 1'b0;
      clr_after_q <= 1'b0;
      found_q     <= 1'b0;
      scan_rd_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      low_q       <= low_d;
      high_q      <= high_d;
      ovalid_q    <= ovalid_d;
      clr_after_q <= clr_after_d;
      found_q     <= found_d;
      scan_rd_q   <= scan_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q    <= cum_d;
    lo_run_q <= lo_run_d;
    cur_q    <= cur_d;
    out_q    <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_word_o  = out_q;

  // checks
  `PCS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(out_word_o))
  `PCS_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != StIdle) |-> in_stall_o)
  `PCS_ASSERT(a_total_sat, clk_i, rst_ni, total_q <= MaxCount)
endmodule
`default_nettype wire

// ===== rtl/pcs_divider.sv =====
// restoring divider, one quotient bit per cycle, for the stretch mapping
// depends on nothing outside itself
`default_nettype none
module pcs_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [16:0] num_i,
  input  wire logic [9:0]  den_i,
  output logic             done_o,
  output logic [7:0]       quot_o
);
  logic [16:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [9:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  // load on start, else one step: shift remainder in, compare to divisor
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[16]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {8'd0, den_q}) begin
        rem_d = 17'(trial - {8'd0, den_q});
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = trial[16:0];
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[7:0];
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// testbench for percentile_contrast_stretch: two-pass frames, random idling and stalls
// depends on pcs_pkg and the percentile_contrast_stretch rtl
// results are predicted per word and checked in order by a scoreboard class
`default_nettype none
module testbench;

  localparam int unsigned SatLimit = 64;
  localparam int unsigned NumItems = 850;
  localparam int unsigned SettleCycles = 600;
  localparam int unsigned CycleLimit = 400000;

  // scoreboard: stretch predictor and queue of expected output words
  class stretch_scoreboard;
    int unsigned level_count[pcs_pkg::NumLevels];
    int unsigned frame_total;
    logic [7:0]  low_lvl, high_lvl, low_dflt, high_dflt;
    pcs_pkg::out_word_t expected_words[$];
    int          fail_count;

    function new();
      foreach (level_count[i]) level_count[i] = 0;
      frame_total = 0;
      low_lvl = 8'd0;
      high_lvl = 8'd255;
      low_dflt = 8'd0;
      high_dflt = 8'd255;
      fail_count = 0;
    endfunction

    function void set_register(logic [0:0] idx, logic [7:0] data);
      if (idx == pcs_pkg::CfgLowDefault) low_dflt = data;
      else high_dflt = data;
    endfunction

    function void find_levels();
      longint cum;
      longint tot;
      logic [7:0] lo, hi;
      cum = 0;
      tot = frame_total;
      lo = low_dflt;
      hi = high_dflt;
      for (int lv = 0; lv < pcs_pkg::NumLevels; lv++) begin
        cum += level_count[lv];
        if (cum * 10 < tot) lo = lv[7:0];
        if (cum * 10 > tot * 9) begin
          hi = lv[7:0];
          break;
        end
      end
      low_lvl = lo;
      high_lvl = hi;
    endfunction

    function logic [7:0] stretch(logic [7:0] v);
      longint span, num;
      if (v < low_lvl) return 8'd0;
      if (v > high_lvl) return 8'd255;
      span = longint'(high_lvl - low_lvl) + 1;
      num = longint'(v - low_lvl) * 255;
      return 8'((num * 2 + span) / (span * 2));
    endfunction

    // note an accepted input word
    function void note_input(pcs_pkg::in_word_t w);
      pcs_pkg::out_word_t r;
      if (w.operation == pcs_pkg::OpHist) begin
        if (level_count[w.pixel_value] < SatLimit) level_count[w.pixel_value]++;
        if (frame_total < SatLimit) frame_total++;
        if (w.frame_last) find_levels();
      end else begin
        r.stretched_pixel = stretch(w.pixel_value);
        r.result_last = w.frame_last;
        r.low_point = low_lvl;
        r.high_point = high_lvl;
        expected_words.push_back(r);
        if (w.frame_last) begin
          foreach (level_count[i]) level_count[i] = 0;
          frame_total = 0;
        end
      end
    endfunction

    // check an accepted output word against the oldest expectation
    function void check_result(pcs_pkg::out_word_t got);
      pcs_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, got);
        fail_count++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.stretched_pixel !== exp_w.stretched_pixel) begin
        $display("%0t: stretched_pixel expected %0d actual %0d", $time,
                 exp_w.stretched_pixel, got.stretched_pixel);
        fail_count++;
      end
      if (got.result_last !== exp_w.result_last) begin
        $display("%0t: result_last expected %0d actual %0d", $time,
                 exp_w.result_last, got.result_last);
        fail_count++;
      end
      if (got.low_point !== exp_w.low_point) begin
        $display("%0t: low_point expected %0d actual %0d", $time,
                 exp_w.low_point, got.low_point);
        fail_count++;
      end
      if (got.high_point !== exp_w.high_point) begin
        $display("%0t: high_point expected %0d actual %0d", $time,
                 exp_w.high_point, got.high_point);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  pcs_pkg::in_word_t  in_word_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  pcs_pkg::out_word_t out_word_o;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  stretch_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  logic        quiet = 1'b0;

  percentile_contrast_stretch #(.MAX_PIXELS(SatLimit)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall_i = !quiet && ($urandom_range(99) < 8);
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
  end

  // send one word, with random idle cycles before it
  task automatic send_word(logic op, logic [7:0] pix, logic last);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i.operation = op;
    in_word_i.pixel_value = pix;
    in_word_i.frame_last = last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(in_word_i);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [0:0] idx, logic [7:0] data);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one frame: histogram pass then mapping pass, optionally without end marks
  task automatic run_frame(int n, int base, int spread, bit hist_last, bit map_last);
    logic [7:0] pix[$];
    int v;
    for (int i = 0; i < n; i++) begin
      v = base + int'($urandom_range(spread)) - spread / 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      pix.push_back(v[7:0]);
    end
    foreach (pix[i]) send_word(pcs_pkg::OpHist, pix[i], hist_last && (i == n - 1));
    foreach (pix[i]) begin
      if ($urandom_range(3) == 0) v = int'($urandom_range(255));
      else v = int'(pix[i]);
      send_word(pcs_pkg::OpMap, v[7:0], map_last && (i == n - 1));
    end
  endtask

  initial begin
    int n, sel;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (SettleCycles) @(posedge clk_i);

    // mapping before any scan uses reset levels
    send_word(pcs_pkg::OpMap, 8'd0, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd255, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd128, 1'b0);
    // extremes of the histogram, then a mapping pass
    send_word(pcs_pkg::OpHist, 8'd0, 1'b0);
    send_word(pcs_pkg::OpHist, 8'd255, 1'b0);
    send_word(pcs_pkg::OpHist, 8'd100, 1'b0);
    send_word(pcs_pkg::OpHist, 8'd101, 1'b1);
    send_word(pcs_pkg::OpMap, 8'd0, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd100, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd101, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd255, 1'b1);
    // inverted levels: low default above the high level found
    write_register(pcs_pkg::CfgLowDefault, 8'd200);
    send_word(pcs_pkg::OpHist, 8'd0, 1'b0);
    send_word(pcs_pkg::OpHist, 8'd0, 1'b0);
    send_word(pcs_pkg::OpHist, 8'd0, 1'b0);
    send_word(pcs_pkg::OpHist, 8'd5, 1'b1);
    send_word(pcs_pkg::OpMap, 8'd3, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd5, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd150, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd255, 1'b1);
    // single bright pixel with odd defaults
    write_register(pcs_pkg::CfgHighDefault, 8'd0);
    write_register(pcs_pkg::CfgLowDefault, 8'd255);
    send_word(pcs_pkg::OpHist, 8'd255, 1'b1);
    send_word(pcs_pkg::OpMap, 8'd255, 1'b0);
    send_word(pcs_pkg::OpMap, 8'd0, 1'b1);

    // random frames
    while (words_sent < NumItems) begin
      quiet = (words_sent > 300 && words_sent < 450);
      if ($urandom_range(9) == 0) begin
        write_register(pcs_pkg::CfgLowDefault, 8'($urandom_range(255)));
        write_register(pcs_pkg::CfgHighDefault, 8'($urandom_range(255)));
      end else if ($urandom_range(14) == 0) begin
        write_register(pcs_pkg::CfgLowDefault, 8'd0);
        write_register(pcs_pkg::CfgHighDefault, 8'd255);
      end
      sel = int'($urandom_range(19));
      n = int'($urandom_range(1, 24));
      if (sel == 0) run_frame(70, int'($urandom_range(255)), 0, 1, 1);      // saturating counts
      else if (sel == 1) run_frame(n, 128, 255, 1, 0);                      // histogram kept
      else if (sel == 2) run_frame(n, int'($urandom_range(255)), 40, 0, 1); // no scan
      else if (sel == 3) begin
        // stray words
        send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else run_frame(n, int'($urandom_range(255)), int'($urandom_range(255)), 1, 1);
    end
    quiet = 1'b0;

    drain();
    if (sb.fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
`default_nettype wire
